@@ rtl/core/omerq_pkg.sv @@
// Shared types, sizes and helpers for the ordered min-extract ring queue.
package omerq_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SLOT_W  = 10;
    localparam int TEXT_W  = 20;
    localparam int CAP_W   = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [TEXT_W-1:0] text;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic start_scan;
        logic scan_step;
        logic move_step;
        logic take_read;
        logic take_finish;
        logic short_finish;
    } omerq_cmd_t;

    typedef struct packed {
        logic pop_go;
        logic scan_done;
        logic move_done;
        logic out_free;
    } omerq_stat_t;

    // Clamp the raw capacity register into 1..DEPTH.
    function automatic logic [CNT_W-1:0] cap_used(input logic [CAP_W-1:0] raw);
        logic [CNT_W-1:0] res;
        if (raw == '0)
            res = CNT_W'(1);
        else if (int'(raw) > DEPTH)
            res = CNT_W'(DEPTH);
        else
            res = CNT_W'(raw);
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] pos,
                                                    input logic [CNT_W-1:0]  cap);
        logic [CNT_W-1:0] n;
        n = CNT_W'(pos) + CNT_W'(1);
        return (n >= cap) ? '0 : n[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/core/omerq_ctrl.sv @@
// Sequencer for push, scan, rotate and extract phases of the ring queue.
module omerq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  omerq_pkg::omerq_stat_t stat,
    output omerq_pkg::omerq_cmd_t  cmd
);
    import omerq_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SHORT   = 6'b000010,
        ST_SCAN    = 6'b000100,
        ST_MOVE    = 6'b001000,
        ST_TAKE_RD = 6'b010000,
        ST_TAKE_WR = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.pop_go)
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_SHORT;
                    end
                end
            end
            ST_SHORT:
            begin
                if (stat.out_free)
                begin
                    cmd.short_finish = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                    state_next = ST_MOVE;
                else
                    cmd.scan_step = 1'b1;
            end
            ST_MOVE:
            begin
                if (stat.move_done)
                    state_next = ST_TAKE_RD;
                else
                    cmd.move_step = 1'b1;
            end
            ST_TAKE_RD:
            begin
                cmd.take_read = 1'b1;
                state_next    = ST_TAKE_WR;
            end
            ST_TAKE_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.take_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/omerq_dp.sv @@
// Entry store, ring pointers, minimum scan and result register of the ring queue.
module omerq_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  omerq_pkg::omerq_cmd_t            cmd,
    output omerq_pkg::omerq_stat_t           stat,
    input  logic                             kind,
    input  logic [omerq_pkg::SLOT_W-1:0]     slot_number,
    input  logic [omerq_pkg::TEXT_W-1:0]     text_position,
    input  logic                             cfg_wr_en,
    input  logic [omerq_pkg::CAP_W-1:0]      cfg_wr_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             ok,
    output logic [omerq_pkg::SLOT_W-1:0]     popped_slot,
    output logic [omerq_pkg::TEXT_W-1:0]     popped_position
);
    import omerq_pkg::*;

    entry_t mem [DEPTH];

    logic [CAP_W-1:0]  cap_reg,  cap_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [ADDR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]  scan_left_reg, scan_left_next;
    logic [ADDR_W-1:0] cmp_pos_reg, cmp_pos_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0] best_pos_reg, best_pos_next;
    logic [TEXT_W-1:0] min_key_reg, min_key_next;
    logic              mv_pend_reg, mv_pend_next;

    logic              kind_reg;
    entry_t            item_reg;

    logic              out_valid_reg, out_valid_next;
    logic              ok_reg, ok_next;
    entry_t            res_reg, res_next;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    logic [CNT_W-1:0]  cap;
    logic              full;
    logic              out_free;

    assign cap      = cap_used(cap_reg);
    assign full     = (count_reg >= cap);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.pop_go    = (kind == KIND_POP) && (count_reg != '0);
    assign stat.scan_done = (scan_left_reg == '0) && !cmp_valid_reg;
    assign stat.move_done = (head_reg == best_pos_reg) && !mv_pend_reg;
    assign stat.out_free  = out_free;

    always_comb
    begin
        cap_next       = cap_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        cmp_pos_next   = cmp_pos_reg;
        cmp_valid_next = 1'b0;
        best_pos_next  = best_pos_reg;
        min_key_next   = min_key_reg;
        mv_pend_next   = 1'b0;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        wr_data        = item_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cmd.start_scan)
        begin
            scan_ptr_next  = head_reg;
            scan_left_next = count_reg;
            min_key_next   = '1;
            best_pos_next  = head_reg;
        end

        // issue one scan read per cycle; compare its data in the next cycle
        if (cmd.scan_step && (scan_left_reg != '0))
        begin
            rd_en          = 1'b1;
            rd_addr        = scan_ptr_reg;
            cmp_valid_next = 1'b1;
            cmp_pos_next   = scan_ptr_reg;
            scan_ptr_next  = wrap_next(scan_ptr_reg, cap);
            scan_left_next = scan_left_reg - CNT_W'(1);
        end

        if (cmp_valid_reg && (rd_data_reg.text < min_key_reg))
        begin
            min_key_next  = rd_data_reg.text;
            best_pos_next = cmp_pos_reg;
        end

        // rotate: read at head now, write the entry at tail next cycle
        if (cmd.move_step && (head_reg != best_pos_reg))
        begin
            rd_en        = 1'b1;
            rd_addr      = head_reg;
            mv_pend_next = 1'b1;
            head_next    = wrap_next(head_reg, cap);
        end

        if (mv_pend_reg)
        begin
            wr_en     = 1'b1;
            wr_addr   = tail_reg;
            wr_data   = rd_data_reg;
            tail_next = wrap_next(tail_reg, cap);
        end

        if (cmd.take_read)
        begin
            rd_en   = 1'b1;
            rd_addr = head_reg;
        end

        if (cmd.take_finish)
        begin
            out_valid_next = 1'b1;
            ok_next        = 1'b1;
            res_next       = rd_data_reg;
            head_next      = wrap_next(head_reg, cap);
            count_next     = count_reg - CNT_W'(1);
        end

        if (cmd.short_finish)
        begin
            out_valid_next = 1'b1;
            res_next       = '0;
            ok_next        = 1'b0;
            if ((kind_reg == KIND_PUSH) && !full)
            begin
                ok_next    = 1'b1;
                wr_en      = 1'b1;
                wr_addr    = tail_reg;
                wr_data    = item_reg;
                tail_next  = wrap_next(tail_reg, cap);
                count_next = count_reg + CNT_W'(1);
            end
        end

        // a capacity write empties the queue
        if (cfg_wr_en)
        begin
            cap_next   = cfg_wr_data;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_left_reg <= '0;
            cmp_valid_reg <= 1'b0;
            mv_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            scan_left_reg <= scan_left_next;
            cmp_valid_reg <= cmp_valid_next;
            mv_pend_reg   <= mv_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_ptr_reg  <= scan_ptr_next;
        cmp_pos_reg   <= cmp_pos_next;
        best_pos_reg  <= best_pos_next;
        min_key_reg   <= min_key_next;
        ok_reg        <= ok_next;
        res_reg       <= res_next;
        if (cmd.accept)
        begin
            kind_reg      <= kind;
            item_reg.slot <= slot_number;
            item_reg.text <= text_position;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign popped_slot     = res_reg.slot;
    assign popped_position = res_reg.text;

endmodule

@@ rtl/core/ordered_min_extract_ring_queue.sv @@
// Top level of the ordered min-extract ring queue.
//
// Requests enter on in_valid/in_ready with kind, slot_number and text_position;
// each request gives exactly one result on out_valid/out_ready (ok, popped_slot,
// popped_position). A push appends at the tail and fails when the ring is full.
// A pop scans from head for the smallest text index (earliest wins on ties),
// rotates the entries ahead of it to the tail, then removes and returns it;
// a pop on an empty queue fails. Failed requests and pushes return zero data.
// A push or a failed pop skips the scan and rotation; a pop's time grows with
// the entries held and rotated, set by the single read port of the entry store
// (one scan read or one move per cycle).
// One request is in flight at a time; the next is taken once the current
// one's result is in the output register, even if that result still waits.
// A stalled receiver holds the result and, after one more request is taken,
// holds that request too. Reset empties the queue and sets the ring capacity
// to 64; cfg_wr_en writes the capacity (0 acts as 1, above DEPTH as DEPTH)
// and empties the queue. Write it only while no request is in flight.
module ordered_min_extract_ring_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [omerq_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [omerq_pkg::SLOT_W-1:0]     slot_number,
    input  logic [omerq_pkg::TEXT_W-1:0]     text_position,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             ok,
    output logic [omerq_pkg::SLOT_W-1:0]     popped_slot,
    output logic [omerq_pkg::TEXT_W-1:0]     popped_position
);
    import omerq_pkg::*;

    omerq_cmd_t  cmd;
    omerq_stat_t stat;

    omerq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    omerq_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .kind            (kind),
        .slot_number     (slot_number),
        .text_position   (text_position),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ok              (ok),
        .popped_slot     (popped_slot),
        .popped_position (popped_position)
    );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the ordered min-extract ring queue.
`timescale 1ns / 1ps

module tb_top;
    import omerq_pkg::*;

    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 700;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 10;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [TEXT_W-1:0] text;
    } request_t;

    typedef struct packed {
        logic              op;
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [TEXT_W-1:0] text;
    } outcome_t;

    typedef enum {RX_OPEN, RX_COIN, RX_DUTY, RX_TRICKLE} rx_mode_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CAP_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_ready;
    logic              kind;
    logic [SLOT_W-1:0] slot_number;
    logic [TEXT_W-1:0] text_position;
    logic              out_valid;
    logic              out_ready;
    logic              ok;
    logic [SLOT_W-1:0] popped_slot;
    logic [TEXT_W-1:0] popped_position;

    ordered_min_extract_ring_queue u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .slot_number     (slot_number),
        .text_position   (text_position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ok              (ok),
        .popped_slot     (popped_slot),
        .popped_position (popped_position)
    );

    // Requests waiting to be driven, and outcomes waiting to come back.
    request_t request_backlog[$];
    outcome_t awaited_outcomes[$];

    // Mirror of the queue contents.
    entry_t ring_mem [DEPTH];
    int     head_idx;
    int     tail_idx;
    int     held;
    int     ring_len;

    int mismatches;
    int queued;
    int n_cfg;
    int n_push_ok;
    int n_push_full;
    int n_pop_ok;
    int n_pop_empty;
    int n_rotated;
    int peak_fill;

    logic     took_req;
    request_t next_req;
    int       burst_left;
    int       gap_left;
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_tick;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int step_ring(input int p);
        return (p + 1 >= ring_len) ? 0 : p + 1;
    endfunction

    task automatic serve_request(input request_t rq, output outcome_t res);
        int               best;
        int               p;
        int               i;
        logic [TEXT_W-1:0] min_key;
        entry_t           e;
        res    = '0;
        res.op = rq.op;
        if (rq.op == KIND_PUSH) begin
            if (held < ring_len) begin
                e.slot = rq.slot;
                e.text = rq.text;
                ring_mem[tail_idx] = e;
                tail_idx = step_ring(tail_idx);
                held++;
                res.ok = 1'b1;
                n_push_ok++;
                if (held > peak_fill)
                    peak_fill = held;
            end
            else
                n_push_full++;
        end
        else if (held == 0)
            n_pop_empty++;
        else
        begin
            // Strict less-than keeps the earliest entry on equal keys.
            best    = head_idx;
            min_key = ring_mem[head_idx].text;
            p       = head_idx;
            for (i = 0; i < held; i++)
            begin
                if (ring_mem[p].text < min_key)
                begin
                    min_key = ring_mem[p].text;
                    best    = p;
                end
                p = step_ring(p);
            end
            // Rotate everything ahead of the winner to the tail, in order.
            for (i = 0; head_idx != best && i < DEPTH; i++)
            begin
                ring_mem[tail_idx] = ring_mem[head_idx];
                head_idx = step_ring(head_idx);
                tail_idx = step_ring(tail_idx);
                n_rotated++;
            end
            e        = ring_mem[head_idx];
            head_idx = step_ring(head_idx);
            held--;
            res.ok   = 1'b1;
            res.slot = e.slot;
            res.text = e.text;
            n_pop_ok++;
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Predict on accepted requests and config writes; check returned results.
    always @(posedge clk)
    begin
        outcome_t res;
        if (!rst_n)
            took_req <= 1'b0;
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_wr_data == '0)
                    ring_len = 1;
                else if (int'(cfg_wr_data) > DEPTH)
                    ring_len = DEPTH;
                else
                    ring_len = int'(cfg_wr_data);
                head_idx = 0;
                tail_idx = 0;
                held     = 0;
                n_cfg++;
            end
            if (in_valid && in_ready)
            begin
                serve_request('{op: kind, slot: slot_number, text: text_position}, res);
                awaited_outcomes.push_back(res);
            end
            if (out_valid && out_ready)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $display("%0t: result with no request waiting, ok=%0h slot=%0h pos=%0h",
                             $time, ok, popped_slot, popped_position);
                    mismatches++;
                end
                else
                begin
                    res = awaited_outcomes.pop_front();
                    check_field("ok", 32'(res.ok), 32'(ok));
                    check_field("popped_slot", 32'(res.slot), 32'(popped_slot));
                    check_field("popped_position", 32'(res.text), 32'(popped_position));
                end
            end
            took_req <= in_valid && in_ready;
        end
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || took_req)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (request_backlog.size() != 0)
            begin
                next_req = request_backlog.pop_front();
                in_valid      <= 1'b1;
                kind          <= next_req.op;
                slot_number   <= next_req.slot;
                text_position <= next_req.text;
                if (burst_left > 1)
                    burst_left--;
                else if ($urandom_range(0, 5) == 0)
                begin
                    // Occasional long stretch with no idling at all.
                    burst_left = $urandom_range(40, 120);
                    gap_left   = 0;
                end
                else
                begin
                    burst_left = $urandom_range(1, 10);
                    gap_left   = $urandom_range(0, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: switch between stall patterns every so often.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(30, 200);
        end
        else
            rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
            RX_DUTY:  out_ready <= (rx_tick % 8) < 3;
            default:  out_ready <= (rx_tick % 12) == 0;
        endcase
    end

    task automatic add_request(input logic op, input logic [SLOT_W-1:0] s,
                               input logic [TEXT_W-1:0] t);
        request_backlog.push_back('{op: op, slot: s, text: t});
        queued++;
    endtask

    function automatic logic [TEXT_W-1:0] random_key();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return TEXT_W'($urandom_range(0, 15));
            default:    return TEXT_W'($urandom);
        endcase
    endfunction

    task automatic add_random(input logic op);
        add_request(op, SLOT_W'($urandom), random_key());
    endtask

    // Sample at the rising edge, where the driver's last update has settled.
    task automatic wait_idle();
        while (request_backlog.size() != 0 || in_valid || awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_idle();
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        int               len;
        int               n;
        int               bias;
        int               i;
        logic [CAP_W-1:0] raw;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        kind          = KIND_PUSH;
        slot_number   = '0;
        text_position = '0;
        out_ready     = 1'b0;
        took_req      = 1'b0;
        burst_left    = 1;
        gap_left      = 0;
        rx_mode       = RX_OPEN;
        rx_left       = 0;
        rx_tick       = 0;
        head_idx      = 0;
        tail_idx      = 0;
        held          = 0;
        ring_len      = DEPTH;
        mismatches    = 0;
        queued        = 0;
        n_cfg         = 0;
        n_push_ok     = 0;
        n_push_full   = 0;
        n_pop_ok      = 0;
        n_pop_empty   = 0;
        n_rotated     = 0;
        peak_fill     = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset capacity: empty pop, extreme fields, equal keys, rotation.
        add_request(KIND_POP,  '1, '1);
        add_request(KIND_PUSH, 10'h3FF, 20'hFFFFF);
        add_request(KIND_PUSH, 10'h000, 20'h00000);
        add_request(KIND_PUSH, 10'h155, 20'h00005);
        add_request(KIND_PUSH, 10'h2AA, 20'h00005);
        add_request(KIND_PUSH, 10'h001, 20'hFFFFF);
        repeat (6) add_request(KIND_POP, '0, '0);

        // Zero capacity behaves as a single position.
        write_capacity(7'd0);
        add_request(KIND_PUSH, 10'h0AA, 20'h12345);
        add_request(KIND_PUSH, 10'h0BB, 20'h00001);
        add_request(KIND_POP,  '0, '0);
        add_request(KIND_POP,  '0, '0);

        // Two positions: full refusal and wrap during rotation.
        write_capacity(7'd2);
        add_request(KIND_PUSH, 10'h100, 20'h00010);
        add_request(KIND_PUSH, 10'h200, 20'h00003);
        add_request(KIND_PUSH, 10'h3FF, 20'h00000);
        add_request(KIND_POP,  '0, '0);
        add_request(KIND_PUSH, 10'h300, 20'h00001);
        add_request(KIND_POP,  '0, '0);
        add_request(KIND_POP,  '0, '0);

        // Oversized capacity clamps to the full store.
        write_capacity(7'd127);
        add_request(KIND_PUSH, 10'h2AA, 20'hAAAAA);
        add_request(KIND_POP,  10'h155, 20'h55555);

        while (queued < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       raw = 7'd0;
                1:       raw = 7'd1;
                2:       raw = 7'd2;
                3:       raw = 7'd64;
                4:       raw = CAP_W'($urandom_range(65, 127));
                5:       raw = 7'd127;
                default: raw = CAP_W'($urandom_range(3, 63));
            endcase
            write_capacity(raw);
            len = (raw == 0) ? 1 : ((int'(raw) > DEPTH) ? DEPTH : int'(raw));

            if ($urandom_range(0, 2) != 0)
            begin
                // Fill past full, then drain past empty, with a little noise.
                n = len + $urandom_range(0, 2);
                for (i = 0; i < n; i++)
                    add_random(($urandom_range(0, 7) == 0) ? KIND_POP : KIND_PUSH);
                n = len + $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    add_random(($urandom_range(0, 7) == 0) ? KIND_PUSH : KIND_POP);
            end
            else
            begin
                bias = $urandom_range(25, 80);
                n    = $urandom_range(20, 100);
                for (i = 0; i < n; i++)
                    add_random(($urandom_range(0, 99) < bias) ? KIND_PUSH : KIND_POP);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d requests over %0d capacity settings: %0d pushes stored, %0d %s",
                 queued, n_cfg, n_push_ok, n_push_full, "refused as full");
        $display("Peak fill %0d; extracted %0d entries with %0d entries rotated ahead of them;",
                 peak_fill, n_pop_ok, n_rotated);
        $display("%0d pops met an empty queue.", n_pop_empty);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout: requests or results stopped moving");
        $display("Test completed with failures");
        $finish;
    end

endmodule
